// ===== rtl/unsigned_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the converter modules.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U2DA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define U2DA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/u2da_pkg.sv =====
// Package with the types and constants of the decimal ASCII converter.
`default_nettype none

package u2da_pkg;

    // Width of the input port and of the converted part of it.
    localparam int IN_WIDTH    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int CONV_WIDTH  = (VALUE_WIDTH < IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;

    // Decimal digits needed: floor(w * log10(2)) + 1, with log10(2) ~ 1233/4096.
    localparam int DIGITS     = (CONV_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_WIDTH  = 4 * DIGITS;
    localparam int IDX_WIDTH  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int STEP_WIDTH = (CONV_WIDTH > 1) ? $clog2(CONV_WIDTH) : 1;

    // Output character coding.
    localparam int CHAR_WIDTH = 6;
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // One queued word: the masked value and its zero classification.
    typedef struct packed {
        logic [CONV_WIDTH-1:0] bits;
        logic                  is_zero;
    } u2da_entry_t;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } u2da_state_t;

endpackage

`default_nettype wire

// ===== rtl/u2da_front.sv =====
// Front part: accepts input words, classifies them and queues them for the back part.
`default_nettype none

module u2da_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [u2da_pkg::IN_WIDTH-1:0] value,
    input  wire logic                          value_valid,
    output logic                               value_ready,
    output u2da_pkg::u2da_entry_t              q_entry,
    output logic                               q_valid,
    input  wire logic                          q_pop
);
    import u2da_pkg::*;

    `include "unsigned_to_decimal_ascii_macros.svh"

    u2da_entry_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0]   count_reg, count_next;
    logic                    push;
    logic                    pop;
    u2da_entry_t             new_entry;

    // Mask the unused upper bits and flag a zero value.
    always_comb
    begin
        new_entry.bits    = value[CONV_WIDTH-1:0];
        new_entry.is_zero = (value[CONV_WIDTH-1:0] == '0);
    end

    // Handshake and queue status.
    assign value_ready = (count_reg != QCNT_WIDTH'(QUEUE_DEPTH));
    assign push        = value_valid && value_ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_pop && q_valid;
    assign q_entry     = entries_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= new_entry;
        end
    end

    `U2DA_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= QCNT_WIDTH'(QUEUE_DEPTH))
    `U2DA_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `U2DA_ASSERT_NEXT(a_count_shrinks, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

// ===== rtl/u2da_back.sv =====
// Back part: shift-and-add-3 binary to BCD conversion and digit emission.
`default_nettype none

module u2da_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire u2da_pkg::u2da_entry_t           q_entry,
    input  wire logic                            q_valid,
    output logic                                 q_pop,
    output logic [u2da_pkg::CHAR_WIDTH-1:0]      digit_char,
    output logic                                 last,
    output logic                                 digit_valid,
    input  wire logic                            digit_ready
);
    import u2da_pkg::*;

    `include "unsigned_to_decimal_ascii_macros.svh"

    u2da_state_t             state_reg, state_next;
    logic [CONV_WIDTH-1:0]   bin_reg;
    logic [BCD_WIDTH-1:0]    bcd_reg;
    logic [BCD_WIDTH-1:0]    bcd_adj;
    logic [STEP_WIDTH-1:0]   step_reg;
    logic [IDX_WIDTH-1:0]    idx_reg;
    logic                    started_reg;
    logic                    out_valid_reg;
    logic [CHAR_WIDTH-1:0]   digit_char_reg;
    logic                    last_reg;
    logic [3:0]              cur_digit;
    logic                    emit_digit;
    logic                    slot_free;
    logic                    advance;
    logic                    load_out;
    logic                    conv_done;

    // Add 3 to every BCD digit of five or more before the next shift.
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    // Digit under emission and leading-zero suppression.
    assign cur_digit  = bcd_reg[BCD_WIDTH-1 -: 4];
    assign emit_digit = started_reg || (cur_digit != 4'd0) || (idx_reg == '0);
    assign slot_free  = !out_valid_reg || digit_ready;
    assign conv_done  = (step_reg == STEP_WIDTH'(CONV_WIDTH - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_entry.is_zero ? S_EMIT : S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (advance && (idx_reg == '0))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        q_pop    = 1'b0;
        advance  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                q_pop = q_valid;
            end
            S_CONV:
            begin
                q_pop = 1'b0;
            end
            S_EMIT:
            begin
                advance  = !emit_digit || slot_free;
                load_out = emit_digit && slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                step_reg    <= '0;
                idx_reg     <= q_entry.is_zero ? '0 : IDX_WIDTH'(DIGITS - 1);
                started_reg <= 1'b0;
            end
            else if (state_reg == S_CONV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg - 1'b1;
                if (load_out)
                begin
                    started_reg <= 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (digit_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Conversion datapath and output word.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bin_reg <= q_entry.bits;
            bcd_reg <= '0;
        end
        else if (state_reg == S_CONV)
        begin
            {bcd_reg, bin_reg} <= {bcd_adj[BCD_WIDTH-2:0], bin_reg, 1'b0};
        end
        else if (advance)
        begin
            bcd_reg <= {bcd_reg[BCD_WIDTH-5:0], 4'd0};
        end
        if (load_out)
        begin
            digit_char_reg <= ASCII_ZERO + {2'b00, cur_digit};
            last_reg       <= (idx_reg == '0);
        end
    end

    assign digit_char  = digit_char_reg;
    assign last        = last_reg;
    assign digit_valid = out_valid_reg;

    `U2DA_ASSERT_SAME(a_pop_only_idle, q_pop, state_reg == S_IDLE)
    `U2DA_ASSERT_SAME(a_bcd_digit_range, state_reg == S_EMIT, cur_digit <= 4'd9)
    `U2DA_ASSERT_NEXT(a_last_ends_run, load_out && (idx_reg == '0), state_reg == S_IDLE)
    `U2DA_ASSERT_NEXT(a_no_stray_output, (state_reg != S_EMIT) && !out_valid_reg,
        !out_valid_reg)

endmodule

`default_nettype wire

// ===== rtl/unsigned_to_decimal_ascii.sv =====
// Top level of the unsigned binary to decimal ASCII converter.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+------------------------
//  input   | value_valid / value_ready  | value[31:0]
//  output  | digit_valid / digit_ready  | digit_char[5:0], last
//
// A value leaves the queue, goes through shift-and-add-3 conversion (none for
// zero) and then through the ten BCD digit positions (one for zero), one position
// per cycle while the output is not stalled; leading zeros are not emitted.
// A two-word queue lets the input side take new values while a run is emitted.
// Reset is asynchronous and active low; it empties the queue and the output stage.
// Output stalls hold the current digit and pause emission without losing words.
`default_nettype none

module unsigned_to_decimal_ascii (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [u2da_pkg::IN_WIDTH-1:0]   value,
    input  wire logic                            value_valid,
    output logic                                 value_ready,
    output logic [u2da_pkg::CHAR_WIDTH-1:0]      digit_char,
    output logic                                 last,
    output logic                                 digit_valid,
    input  wire logic                            digit_ready
);
    import u2da_pkg::*;

    u2da_entry_t q_entry;
    logic        q_valid;
    logic        q_pop;

    // Front part with the queue.
    u2da_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .q_entry     (q_entry),
        .q_valid     (q_valid),
        .q_pop       (q_pop)
    );

    // Back part: conversion and emission.
    u2da_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_entry     (q_entry),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .digit_char  (digit_char),
        .last        (last),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the unsigned binary to decimal ASCII converter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import u2da_pkg::*;

    // One value waiting to be sent, with the idle time to leave before it.
    typedef struct {
        logic [IN_WIDTH-1:0] number;
        int unsigned         gap;
        bit                  drain_first;
    } value_job_t;

    // One expected output word: a digit character and its end-of-run flag.
    typedef struct {
        logic [CHAR_WIDTH-1:0] ch;
        logic                  last;
    } digit_word_t;

    localparam int CORNER_COUNT = 25;
    localparam int RANDOM_COUNT = 145;
    localparam int CALM_TAIL    = 25;
    localparam int SETTLE_WAIT  = 60;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_WIDTH-1:0]   value = '0;
    logic                  value_valid = 1'b0;
    logic                  value_ready;
    logic [CHAR_WIDTH-1:0] digit_char;
    logic                  last;
    logic                  digit_valid;
    logic                  digit_ready = 1'b0;

    value_job_t  value_jobs[$];
    digit_word_t digits_due[$];

    logic        value_taken = 1'b0;
    int unsigned values_accepted = 0;
    int unsigned digits_checked = 0;
    int unsigned mismatches = 0;
    int unsigned send_wait = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_left = 0;

    unsigned_to_decimal_ascii DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .digit_char  (digit_char),
        .last        (last),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready)
    );

    // Free-running clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Expands a value into its decimal digit words, most significant first.
    function automatic void predict_digits(input logic [IN_WIDTH-1:0] number);
        longint unsigned rest;
        int unsigned     msd_first[$];
        digit_word_t     w;
        rest = number;
        if (CONV_WIDTH < 64)
            rest &= (64'd1 << CONV_WIDTH) - 64'd1;
        do
        begin
            msd_first.push_front(int'(rest % 10));
            rest = rest / 10;
        end
        while (rest != 0);
        foreach (msd_first[i])
        begin
            w.ch   = ASCII_ZERO + CHAR_WIDTH'(msd_first[i]);
            w.last = (i == msd_first.size() - 1);
            digits_due.push_back(w);
        end
    endfunction

    // Monitor: records accepted values and checks every digit word that leaves.
    always @(posedge clk)
    begin : monitor
        digit_word_t due;
        value_taken <= rst_n && value_valid && value_ready;
        if (rst_n)
        begin
            if (value_valid && value_ready)
            begin
                predict_digits(value);
                values_accepted++;
            end
            if (digit_valid && digit_ready)
            begin
                digits_checked++;
                if (digits_due.size() == 0)
                begin
                    $display("%0t ns: digit word with none expected: char %0d last %0b",
                             $time, digit_char, last);
                    mismatches++;
                end
                else
                begin
                    due = digits_due.pop_front();
                    if (digit_char !== due.ch)
                    begin
                        $display("%0t ns: digit_char mismatch: expected %0d, actual %0d",
                                 $time, due.ch, digit_char);
                        mismatches++;
                    end
                    if (last !== due.last)
                    begin
                        $display("%0t ns: last mismatch: expected %0b, actual %0b",
                                 $time, due.last, last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Driver: presents queued values, honouring idle gaps and drain pauses.
    always @(negedge clk)
    begin : sender
        value_job_t job;
        logic       next_valid;
        if (rst_n && (!value_valid || value_taken))
        begin
            next_valid = 1'b0;
            if (send_wait != 0)
                send_wait--;
            else if (value_jobs.size() != 0)
            begin
                if (value_jobs[0].gap != 0)
                begin
                    send_wait = value_jobs[0].gap - 1;
                    value_jobs[0].gap = 0;
                end
                else if (!(value_jobs[0].drain_first && digits_due.size() != 0))
                begin
                    job = value_jobs.pop_front();
                    value <= job.number;
                    next_valid = 1'b1;
                end
            end
            value_valid <= next_valid;
        end
    end

    // Receiver: stalls in random bursts, with quiet stretches and a calm tail.
    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                digit_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                digit_ready <= 1'b1;
                if (quiet_left != 0)
                    quiet_left--;
                else if (value_jobs.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 18);
                else if ($urandom_range(0, 99) == 0)
                    quiet_left = $urandom_range(50, 300);
            end
        end
    end

    // Stimulus: corner values first, then random values of every length.
    initial
    begin : stimulus
        logic [IN_WIDTH-1:0] corner_values [CORNER_COUNT];
        value_job_t          job;
        longint unsigned     lo;
        longint unsigned     hi;
        int unsigned         ndig;
        int unsigned         total;
        int unsigned         n;

        corner_values = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
            32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
            32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
            32'd999999999, 32'd1000000000, 32'd4294967295, 32'd4294967294,
            32'h80000000, 32'h55555555, 32'hAAAAAAAA
        };
        foreach (corner_values[i])
        begin
            job.number      = corner_values[i];
            job.gap         = 0;
            job.drain_first = 1'b0;
            value_jobs.push_back(job);
        end

        for (int k = 0; k < RANDOM_COUNT; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    job.number = $urandom;
                2:
                begin
                    // Just either side of a power of ten.
                    lo = 1;
                    repeat ($urandom_range(1, 9))
                        lo *= 10;
                    job.number = IN_WIDTH'(lo + $urandom_range(0, 2) - 1);
                end
                default:
                begin
                    ndig = $urandom_range(1, 10);
                    lo = 1;
                    repeat (ndig - 1)
                        lo *= 10;
                    hi = lo * 10 - 1;
                    if (ndig == 1)
                        lo = 0;
                    if (hi > 64'hFFFF_FFFF)
                        hi = 64'hFFFF_FFFF;
                    job.number = IN_WIDTH'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
                end
            endcase
            // Gaps only in alternate blocks of twenty, and none near the end.
            if ((k / 20) % 2 == 0 && k < RANDOM_COUNT - CALM_TAIL && $urandom_range(0, 2) == 0)
                job.gap = $urandom_range(1, 18);
            else
                job.gap = 0;
            job.drain_first = (k == 0 || k == 60 || k == 120);
            value_jobs.push_back(job);
        end
        total = value_jobs.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (values_accepted < total)
            @(negedge clk);
        for (n = 0; n < 2000 && digits_due.size() != 0; n++)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
        if (digits_due.size() != 0)
        begin
            $display("%0t ns: %0d expected digit words never arrived",
                     $time, digits_due.size());
            mismatches++;
        end

        $display("Sent %0d values (%0d corner cases, %0d random) under random stalls;",
                 values_accepted, CORNER_COUNT, RANDOM_COUNT);
        $display("checked %0d digit words and found %0d mismatches.",
                 digits_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
